// ----- design/step_limited_l1_fit_dp_assert.svh -----
// assertion macros shared by the checker
`ifndef STEP_LIMITED_L1_FIT_DP_ASSERT_SVH
`define STEP_LIMITED_L1_FIT_DP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define SL1FIT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SL1FIT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/sl1fit_pkg.sv -----
`timescale 1ns / 1ps

package sl1fit_pkg;

    localparam int LEVELS    = 512;
    localparam int LVL_W     = $clog2(LEVELS);
    localparam int COST_BITS = 25;
    localparam int SAMPLE_W  = 9;
    localparam int STEP_W    = 9;
    // block length 2*step+1 needs one more bit than the step
    localparam int BLK_W     = STEP_W + 1;
    // address arithmetic on the pass counter reaches LEVELS-1+2*step
    localparam int CNT_W     = $clog2(LEVELS + 2 * (2 ** STEP_W));
    localparam int DIST_W    = (SAMPLE_W > LVL_W) ? SAMPLE_W : LVL_W;
    localparam int IN_TW     = 16;
    localparam int OUT_TW    = 32;

    localparam logic [COST_BITS-1:0] COST_MAX  = {COST_BITS{1'b1}};
    localparam logic [STEP_W-1:0]    STEP_RST  = STEP_W'(1);
    localparam logic [LVL_W-1:0]     LAST_LVL  = LVL_W'(LEVELS - 1);

    typedef enum logic [1:0] {
        PASS_FILL,
        PASS_FWD,
        PASS_BWD
    } pass_t;

    typedef struct packed {
        logic  load;
        logic  start;
        pass_t mode;
        logic  swap;
        logic  emit;
    } sl1fit_cmd_t;

    typedef struct packed {
        logic busy;
        logic out_full;
    } sl1fit_stat_t;

    typedef struct packed {
        logic [BLK_W-1:0]     pos;
        logic [COST_BITS-1:0] g;
    } gent_t;

    function automatic logic [COST_BITS-1:0] cmin(input logic [COST_BITS-1:0] a,
                                                  input logic [COST_BITS-1:0] b);
        return (b < a) ? b : a;
    endfunction

endpackage

// ----- design/sl1fit_ctrl.sv -----
`timescale 1ns / 1ps

module sl1fit_ctrl import sl1fit_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         s_tready,
    input  logic         m_tready,
    input  sl1fit_stat_t stat,
    output sl1fit_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_FWD,
        ST_BWD,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   ready_reg;

    // next state and commands to the datapath
    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = '0;
        cmd.mode   = PASS_FILL;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid && ready_reg)
                begin
                    cmd.load  = 1'b1;
                    cmd.start = 1'b1;
                    last_next = s_tlast;
                    if (s_tuser)
                    begin
                        cmd.mode   = PASS_FILL;
                        state_next = ST_FILL;
                    end
                    else
                    begin
                        cmd.mode   = PASS_FWD;
                        state_next = ST_FWD;
                    end
                end
            end
            ST_FILL, ST_BWD:
            begin
                if (!stat.busy)
                begin
                    cmd.swap   = 1'b1;
                    state_next = last_reg ? ST_EMIT : ST_IDLE;
                end
            end
            ST_FWD:
            begin
                if (!stat.busy)
                begin
                    cmd.start  = 1'b1;
                    cmd.mode   = PASS_BWD;
                    state_next = ST_BWD;
                end
            end
            ST_EMIT:
            begin
                if (!stat.out_full || m_tready)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
            ready_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
            ready_reg <= (state_next == ST_IDLE);
        end
    end

    assign s_tready = ready_reg;

endmodule

// ----- design/sl1fit_dp.sv -----
`timescale 1ns / 1ps

module sl1fit_dp import sl1fit_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  sl1fit_cmd_t         cmd,
    output sl1fit_stat_t        stat,
    input  logic [SAMPLE_W-1:0] sample_in,
    input  logic                cfg_we,
    input  logic [STEP_W-1:0]   cfg_data,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [OUT_TW-1:0]   m_tdata
);

    // cost rows and block prefix-minimum store
    logic [COST_BITS-1:0] row_a [LEVELS];
    logic [COST_BITS-1:0] row_b [LEVELS];
    gent_t                gmem  [LEVELS];

    logic [STEP_W-1:0]    step_reg;
    logic [SAMPLE_W-1:0]  x_reg;
    logic                 active_reg;
    logic                 run_reg;
    pass_t                mode_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [BLK_W-1:0]     fpos_reg, bpos_reg, posl_reg;
    logic [COST_BITS-1:0] g_reg, r_reg, acc_reg;

    logic [COST_BITS-1:0] a_q_reg, b_q_reg;
    gent_t                g_q_reg;

    logic                 p1_v_reg, p1_rep_reg, p1_out_reg;
    pass_t                p1_mode_reg;
    logic [LVL_W-1:0]     p1_idx_reg, p1_u_reg, p1_hi_reg;

    logic                 p2_v_reg, p2_zero_reg, p2_ronly_reg, p2_gonly_reg;
    logic [LVL_W-1:0]     p2_idx_reg;
    logic [COST_BITS-1:0] p2_r_reg, p2_g_reg;

    logic                 p3_v_reg;
    logic [LVL_W-1:0]     p3_idx_reg;
    logic [COST_BITS:0]   p3_sum_reg;

    logic                 out_valid_reg;
    logic [COST_BITS-1:0] out_data_reg;

    // issue address generation
    logic [CNT_W-1:0]     cnt_end, u_full, t_full, s_full;
    logic                 rep, out_ok;
    logic [LVL_W-1:0]     u_addr, hi_addr, rd_addr, s_idx;
    logic [BLK_W-1:0]     wlast;

    assign wlast   = {step_reg, 1'b0};
    assign cnt_end = (mode_reg == PASS_BWD) ? CNT_W'(LEVELS - 1) + CNT_W'(step_reg)
                                            : CNT_W'(LEVELS - 1);
    assign rep     = cnt_reg > CNT_W'(LEVELS - 1);
    assign u_full  = CNT_W'(LEVELS - 1) - cnt_reg;
    assign u_addr  = rep ? '0 : u_full[LVL_W-1:0];
    assign s_full  = CNT_W'(LEVELS - 1) + CNT_W'(step_reg) - cnt_reg;
    assign t_full  = s_full + CNT_W'(step_reg);
    assign hi_addr = (t_full > CNT_W'(LEVELS - 1)) ? LAST_LVL : t_full[LVL_W-1:0];
    assign s_idx   = s_full[LVL_W-1:0];
    assign out_ok  = cnt_reg >= CNT_W'(step_reg);
    assign rd_addr = (mode_reg == PASS_BWD) ? u_addr : cnt_reg[LVL_W-1:0];

    // stage 1 combinational: running minima and block test
    logic [COST_BITS-1:0] old_q, g_new, r_new;
    logic                 bend, same, hi_end;

    assign old_q  = active_reg ? b_q_reg : a_q_reg;
    assign g_new  = (fpos_reg == '0) ? old_q : cmin(g_reg, old_q);
    // repeated reads of level zero keep the suffix minimum of the first block
    assign bend   = !p1_rep_reg && ((bpos_reg == wlast) || (p1_u_reg == LAST_LVL));
    assign r_new  = bend ? old_q : cmin(r_reg, old_q);
    assign same   = BLK_W'(p1_hi_reg - p1_u_reg) <= g_q_reg.pos;
    assign hi_end = (p1_hi_reg == LAST_LVL);

    // stage 2 combinational: window minimum plus distance
    logic [COST_BITS-1:0] base;
    logic [DIST_W-1:0]    xd, id, lvl_gap;

    always_comb
    begin
        if (p2_zero_reg)
            base = '0;
        else if (p2_ronly_reg)
            base = p2_r_reg;
        else if (p2_gonly_reg)
            base = p2_g_reg;
        else
            base = cmin(p2_r_reg, p2_g_reg);
    end

    assign xd      = DIST_W'(x_reg);
    assign id      = DIST_W'(p2_idx_reg);
    assign lvl_gap = (xd >= id) ? (xd - id) : (id - xd);

    // stage 3 combinational: saturation
    logic [COST_BITS-1:0] new_val;
    assign new_val = p3_sum_reg[COST_BITS] ? COST_MAX : p3_sum_reg[COST_BITS-1:0];

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= STEP_RST;
            active_reg    <= 1'b0;
            run_reg       <= 1'b0;
            mode_reg      <= PASS_FILL;
            cnt_reg       <= '0;
            fpos_reg      <= '0;
            bpos_reg      <= '0;
            posl_reg      <= '0;
            p1_v_reg      <= 1'b0;
            p2_v_reg      <= 1'b0;
            p3_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                step_reg <= cfg_data;
            if (cmd.swap)
                active_reg <= ~active_reg;

            // pass sequencing
            if (cmd.start)
            begin
                run_reg  <= 1'b1;
                mode_reg <= cmd.mode;
                cnt_reg  <= '0;
                fpos_reg <= '0;
                bpos_reg <= posl_reg;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == cnt_end)
                    run_reg <= 1'b0;
            end

            // block position counters
            if (p1_v_reg && (p1_mode_reg == PASS_FWD))
            begin
                fpos_reg <= (fpos_reg == wlast) ? '0 : fpos_reg + BLK_W'(1);
                if (p1_idx_reg == LAST_LVL)
                    posl_reg <= fpos_reg;
            end
            if (p1_v_reg && (p1_mode_reg == PASS_BWD) && !p1_rep_reg)
                bpos_reg <= (bpos_reg == '0) ? wlast : bpos_reg - BLK_W'(1);

            p1_v_reg <= run_reg;
            p2_v_reg <= p1_v_reg && ((p1_mode_reg == PASS_FILL) ||
                        ((p1_mode_reg == PASS_BWD) && p1_out_reg));
            p3_v_reg <= p2_v_reg;

            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            x_reg <= sample_in;

        p1_mode_reg <= mode_reg;
        p1_idx_reg  <= (mode_reg == PASS_BWD) ? s_idx : cnt_reg[LVL_W-1:0];
        p1_u_reg    <= u_addr;
        p1_hi_reg   <= hi_addr;
        p1_rep_reg  <= rep;
        p1_out_reg  <= out_ok;

        if (p1_v_reg && (p1_mode_reg == PASS_FWD))
            g_reg <= g_new;
        if (p1_v_reg && (p1_mode_reg == PASS_BWD))
            r_reg <= r_new;

        p2_idx_reg   <= p1_idx_reg;
        p2_zero_reg  <= (p1_mode_reg == PASS_FILL);
        p2_ronly_reg <= same && hi_end;
        p2_gonly_reg <= same && !hi_end;
        p2_r_reg     <= r_new;
        p2_g_reg     <= g_q_reg.g;

        p3_idx_reg <= p2_idx_reg;
        p3_sum_reg <= {1'b0, base} + (COST_BITS + 1)'(lvl_gap);

        // running minimum of the new row
        if (cmd.start)
            acc_reg <= COST_MAX;
        else if (p3_v_reg)
            acc_reg <= cmin(acc_reg, new_val);

        if (cmd.emit)
            out_data_reg <= acc_reg;
    end

    // memory ports
    always_ff @(posedge clk)
    begin
        a_q_reg <= row_a[rd_addr];
        b_q_reg <= row_b[rd_addr];
        g_q_reg <= gmem[hi_addr];
        if (p1_v_reg && (p1_mode_reg == PASS_FWD))
            gmem[p1_idx_reg] <= '{pos: fpos_reg, g: g_new};
        if (p3_v_reg && active_reg)
            row_a[p3_idx_reg] <= new_val;
        if (p3_v_reg && !active_reg)
            row_b[p3_idx_reg] <= new_val;
    end

    assign stat.busy     = run_reg | p1_v_reg | p2_v_reg | p3_v_reg;
    assign stat.out_full = out_valid_reg;
    assign m_tvalid      = out_valid_reg;
    assign m_tdata       = {{(OUT_TW - COST_BITS){1'b0}}, out_data_reg};

endmodule

// ----- design/step_limited_l1_fit_dp.sv -----
`timescale 1ns / 1ps

// Bounded-step L1 fit over 512 levels. Each input word carries one sample;
// tuser marks the first sample of a sequence and tlast the final one, after
// which one output word gives the least total absolute deviation. A first
// sample takes one pass writing the cost row. Any later sample takes a
// forward pass that builds block prefix minima of the old row, then a
// backward pass that forms suffix minima and combines both into the sliding
// window minimum, one level per cycle, limited by the single read port of
// each row memory. A result waits in the output register while the next
// word is taken.
// max_step (reset 1) may be written only while no sample is in progress.
module step_limited_l1_fit_dp import sl1fit_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [IN_TW-1:0]    s_tdata,   // [8:0] sample, rest zero
    input  logic                s_tuser,   // [0] first
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_TW-1:0]   m_tdata,   // [24:0] min_cost, rest zero
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [STEP_W-1:0]   cfg_data   // [8:0] max_step
);

    sl1fit_cmd_t  cmd;
    sl1fit_stat_t stat;

    // sequencing
    sl1fit_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // row memories and arithmetic
    sl1fit_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .sample_in (s_tdata[SAMPLE_W-1:0]),
        .cfg_we    (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

    assign cfg_ready = 1'b1;

endmodule

// ----- design/sl1fit_chk.sv -----
`timescale 1ns / 1ps

`include "step_limited_l1_fit_dp_assert.svh"

module sl1fit_chk import sl1fit_pkg::*; (
    input logic              clk,
    input logic              rst_n,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [OUT_TW-1:0] m_tdata
);

    // a stalled output word holds
    `SL1FIT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output word changed while stalled")

    // padding bits of the output word stay zero
    `SL1FIT_ASSERT_NOW(a_out_pad, m_tvalid, m_tdata[OUT_TW-1:COST_BITS] == '0, "output padding not zero")

    // one word at a time: the block is busy right after taking a word
    `SL1FIT_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "ready right after accepted word")

    // a new result appears only while inputs are held off
    `SL1FIT_ASSERT_NOW(a_emit_busy, $rose(m_tvalid), !$past(s_tready), "result raised while idle")

endmodule

bind step_limited_l1_fit_dp sl1fit_chk u_chk (.*);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps

import sl1fit_pkg::*;

// tracks the cost rows of the fit and holds the min_cost values still owed
class fit_scoreboard;

    bit [COST_BITS-1:0] cost_row [2][LEVELS];
    bit                 cur_row;
    bit [STEP_W-1:0]    fit_step;
    bit [24:0]          owed_cost [$];
    int                 errors;

    function new();
        cur_row  = 1'b0;
        fit_step = STEP_RST;
        errors   = 0;
    endfunction

    function void set_step(bit [STEP_W-1:0] v);
        fit_step = v;
    endfunction

    // fold one accepted sample into the cost row
    function void note_sample(bit [SAMPLE_W-1:0] x, bit is_first, bit is_last);
        int win [LEVELS];
        int head, tail, nxt, hi, s, h;
        bit [COST_BITS:0]   sum;
        bit [COST_BITS-1:0] gap, base, best;
        bit old_r, new_r;
        old_r = cur_row;
        new_r = !cur_row;
        h = int'(fit_step);
        head = 0;
        tail = 0;
        nxt = 0;
        for (s = 0; s < LEVELS; s++)
        begin
            gap = (x > s) ? COST_BITS'(x - s) : COST_BITS'(s - x);
            if (is_first)
                base = '0;
            else
            begin
                // sliding window minimum over old row, clipped at the ends
                hi = (s + h > LEVELS - 1) ? LEVELS - 1 : s + h;
                while (nxt <= hi)
                begin
                    while (tail > head && cost_row[old_r][win[tail-1]] >= cost_row[old_r][nxt])
                        tail--;
                    win[tail] = nxt;
                    tail++;
                    nxt++;
                end
                while (win[head] < s - h)
                    head++;
                base = cost_row[old_r][win[head]];
            end
            sum = {1'b0, base} + {1'b0, gap};
            cost_row[new_r][s] = sum[COST_BITS] ? COST_MAX : sum[COST_BITS-1:0];
        end
        cur_row = new_r;
        if (is_last)
        begin
            best = cost_row[new_r][0];
            for (s = 1; s < LEVELS; s++)
                if (cost_row[new_r][s] < best)
                    best = cost_row[new_r][s];
            owed_cost = {owed_cost, 25'(best)};
        end
    endfunction

    // compare one output word with the oldest owed value
    function void check_cost(bit [24:0] got);
        bit [24:0] want;
        if (owed_cost.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected output word: min_cost %0d", got);
        end
        else
        begin
            want = owed_cost.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= 10)
                    $display("min_cost mismatch: expected %0d, got %0d", want, got);
            end
        end
    endfunction
endclass

module tb_top;
    import sl1fit_pkg::*;

    localparam int IDLE_WAIT  = 2000;
    localparam int HOLD_LEN   = 8000;
    localparam int DOG_LIMIT  = 60000;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    logic [IN_TW-1:0]    s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                m_tvalid;
    logic                m_tready;
    logic [OUT_TW-1:0]   m_tdata;
    logic                cfg_valid;
    logic                cfg_ready;
    logic [STEP_W-1:0]   cfg_data;

    fit_scoreboard sb;
    bit  hold_req;
    int  burst_left;
    int  idle_cycles;

    step_limited_l1_fit_dp dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // output side check
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_cost(m_tdata[24:0]);
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= DOG_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // receiver: random ready modes, plus one long hold-off on request
    initial
    begin
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_LEN) @(posedge clk);
                hold_req = 1'b0;
            end
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 2);
                mode_left = $urandom_range(20, 400);
            end
            mode_left--;
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // offer one word and wait until it is taken; valid stays high on return only while a burst lasts
    task automatic send_word(bit [SAMPLE_W-1:0] x, bit is_first, bit is_last);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_TW'(x);
        s_tuser  <= is_first;
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_sample(x, is_first, is_last);
        // burst and gap pattern of the sender
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            if ($urandom_range(0, 5) == 0)
                repeat ($urandom_range(1, 1500)) @(posedge clk);
            else
                repeat ($urandom_range(1, 40)) @(posedge clk);
            burst_left = $urandom_range(0, 8);
        end
    endtask

    // let the block drain completely
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (sb.owed_cost.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
    endtask

    task automatic write_step(bit [STEP_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_step(v);
    endtask

    // one sequence with random content; some are left open or restarted
    task automatic random_seq(int len);
        bit [SAMPLE_W-1:0] x;
        int kind, i, drift;
        bit no_last;
        kind = $urandom_range(0, 3);
        no_last = ($urandom_range(0, 7) == 0);
        x = SAMPLE_W'($urandom);
        for (i = 0; i < len; i++)
        begin
            case (kind)
                0: x = SAMPLE_W'($urandom);
                1:
                begin
                    drift = int'(x) + int'($urandom_range(0, 8)) - 4;
                    x = (drift < 0) ? '0 : (drift > 511) ? 9'd511 : SAMPLE_W'(drift);
                end
                2: x = $urandom_range(0, 1) ? 9'd511 : 9'd0;
                default: x = $urandom_range(0, 1) ? SAMPLE_W'($urandom_range(0, 15))
                                                  : SAMPLE_W'($urandom);
            endcase
            send_word(x, i == 0 || (no_last && $urandom_range(0, 5) == 0),
                      i == len - 1 && !no_last);
        end
    endtask

    initial
    begin
        bit [STEP_W-1:0] steps [8];
        int p, sent;
        sb = new();
        hold_req = 1'b0;
        burst_left = 0;
        rst_n <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        s_tlast <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: single samples at the extremes and the middle, then one alternating sequence, reset step of one
        send_word(9'd0, 1, 1);
        send_word(9'd511, 1, 1);
        send_word(9'd255, 1, 1);
        send_word(9'd0, 1, 0);
        send_word(9'd511, 0, 0);
        send_word(9'd0, 0, 0);
        send_word(9'd511, 0, 1);
        // median case with a zero step
        wait_idle();
        write_step(9'd0);
        send_word(9'd3, 1, 0);
        send_word(9'd500, 0, 0);
        send_word(9'd7, 0, 1);
        send_word(9'd511, 1, 0);
        send_word(9'd0, 0, 1);
        // widest step, window covers the whole row
        wait_idle();
        write_step(9'd511);
        send_word(9'd511, 1, 0);
        send_word(9'd0, 0, 0);
        send_word(9'd511, 0, 1);
        send_word(9'd100, 1, 0);
        send_word(9'd100, 0, 0);
        send_word(9'd300, 1, 1);

        // random phases over several step settings
        steps[0] = 9'd0;
        steps[1] = 9'd511;
        steps[2] = 9'd1;
        steps[3] = STEP_W'($urandom_range(2, 20));
        steps[4] = STEP_W'($urandom);
        steps[5] = 9'd2;
        steps[6] = 9'd255;
        steps[7] = STEP_W'($urandom_range(0, 6));
        for (p = 0; p < 8; p++)
        begin
            wait_idle();
            write_step(steps[p]);
            if (p == 3)
                hold_req = 1'b1;
            sent = 0;
            while (sent < 60)
            begin
                int len;
                len = $urandom_range(1, 12);
                random_seq(len);
                sent += len;
            end
        end

        // drain and report
        s_tvalid <= 1'b0;
        while (sb.owed_cost.size() != 0)
            @(posedge clk);
        repeat (IDLE_WAIT) @(posedge clk);
        if (sb.errors == 0 && sb.owed_cost.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+design
design/sl1fit_pkg.sv
design/sl1fit_ctrl.sv
design/sl1fit_dp.sv
design/step_limited_l1_fit_dp.sv
design/sl1fit_chk.sv
tb/sv/tb_top.sv
